// File: rtl/ps2kbd_pkg.sv
package ps2kbd_pkg;

  localparam int KEY_SLOTS = 8;
  localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int REP_W = $clog2(KEY_SLOTS + 1);
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_HOST    = 2'd0;
  localparam logic [1:0] CMD_PRESS   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  localparam logic [1:0] PH_FREE     = 2'd0;
  localparam logic [1:0] PH_HOLD     = 2'd1;
  localparam logic [1:0] PH_PRESSED  = 2'd2;
  localparam logic [1:0] PH_RELEASED = 2'd3;

  localparam logic [1:0] SUB_NONE = 2'd0;
  localparam logic [1:0] SUB_LEDS = 2'd1;
  localparam logic [1:0] SUB_SET  = 2'd2;
  localparam logic [1:0] SUB_TYPM = 2'd3;

  localparam logic [7:0] HC_LEDS     = 8'hed;
  localparam logic [7:0] HC_ECHO     = 8'hee;
  localparam logic [7:0] HC_SCANSET  = 8'hf0;
  localparam logic [7:0] HC_ID       = 8'hf2;
  localparam logic [7:0] HC_TYPM     = 8'hf3;
  localparam logic [7:0] HC_ENABLE   = 8'hf4;
  localparam logic [7:0] HC_DISABLE  = 8'hf5;
  localparam logic [7:0] HC_DEFAULTS = 8'hf6;
  localparam logic [7:0] HC_RESET    = 8'hff;

  localparam logic [7:0] B_ACK     = 8'hfa;
  localparam logic [7:0] B_RESEND  = 8'hfe;
  localparam logic [7:0] B_ID0     = 8'hab;
  localparam logic [7:0] B_ID1     = 8'h83;
  localparam logic [7:0] B_BAT_OK  = 8'haa;
  localparam logic [7:0] B_SET2    = 8'h02;
  localparam logic [7:0] B_EXT     = 8'he0;
  localparam logic [7:0] B_BREAK   = 8'hf0;
  localparam logic [6:0] TYPM_DEF  = 7'h2b;

  localparam logic [7:0] KEY_PAUSE = 8'h13;
  localparam logic [7:0] KEY_PRTSC = 8'h2c;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] led_state;
  } out_item_t;

  typedef struct packed {
    logic ld_item;
    logic do_host;
    logic do_key;
    logic tick_start;
    logic k_clr;
    logic emit_reply;
    logic emit_key;
    logic slot_upd;
    logic walk_next;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_host;
    logic is_tick;
    logic active;
    logic eligible;
    logic fits;
    logic zero_len;
    logic last_k;
    logic last_r;
    logic wi_last;
    logic can_push;
    logic hvalid;
  } ctl_stat_t;

  localparam logic [7:0] CODE_TAB [256] = '{
    8'h5a,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h66,8'h0d,8'h00,8'h00,8'h00,8'h5a,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h58,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h76,8'h00,8'h00,8'h00,8'h00,
    8'h29,8'h7d,8'h7a,8'h69,8'h6c,8'h6b,8'h75,8'h74,8'h72,8'h00,8'h00,8'h00,8'h00,8'h70,8'h71,8'h00,
    8'h45,8'h16,8'h1e,8'h26,8'h25,8'h2e,8'h36,8'h3d,8'h3e,8'h46,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h1c,8'h32,8'h21,8'h23,8'h24,8'h2b,8'h34,8'h33,8'h43,8'h3b,8'h42,8'h4b,8'h3a,8'h31,8'h44,
    8'h4d,8'h15,8'h2d,8'h1b,8'h2c,8'h3c,8'h2a,8'h1d,8'h22,8'h1a,8'h35,8'h1f,8'h27,8'h2f,8'h00,8'h00,
    8'h70,8'h69,8'h72,8'h7a,8'h6b,8'h73,8'h74,8'h6c,8'h75,8'h7d,8'h7c,8'h79,8'h00,8'h7b,8'h71,8'h4a,
    8'h05,8'h06,8'h04,8'h0c,8'h03,8'h0b,8'h83,8'h0a,8'h01,8'h09,8'h78,8'h07,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h77,8'h7e,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h12,8'h59,8'h14,8'h14,8'h11,8'h11,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h54,8'h5b,8'h41,8'h4a,8'h49,8'h5d,
    8'h4c,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h4e,8'h0e,8'h55,8'h52,8'h00,
    8'h00,8'h00,8'h61,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  // bit [key], key 0 first
  localparam logic [0:255] PLAIN_MAP = {
    8'h00,8'hc4,8'h08,8'h10,8'h80,8'h00,8'hff,8'hc0,8'h7f,8'hff,8'hff,8'he0,8'hff,8'hf6,8'hff,8'hf0,
    8'h00,8'h00,8'hc0,8'h00,8'he8,8'h00,8'h00,8'h3f,8'h80,8'h00,8'h00,8'h1e,8'h20,8'h00,8'h00,8'h00
  };

  localparam logic [0:255] MAPPED_MAP = {
    8'h80,8'hc4,8'h18,8'h10,8'hff,8'h8e,8'hff,8'hc0,8'h7f,8'hff,8'hff,8'hfc,8'hff,8'hf7,8'hff,8'hf0,
    8'h00,8'h00,8'hc0,8'h00,8'hfc,8'h00,8'h00,8'h3f,8'h80,8'h00,8'h00,8'h1e,8'h20,8'h00,8'h00,8'h00
  };

  localparam logic [31:0] RATE_TAB [32] = '{
    32'd33333, 32'd37453, 32'd41667, 32'd45872, 32'd48309, 32'd54054, 32'd58480, 32'd62500,
    32'd66667, 32'd75188, 32'd83333, 32'd91743, 32'd100000, 32'd108696, 32'd116279, 32'd125000,
    32'd133333, 32'd149254, 32'd166667, 32'd181818, 32'd200000, 32'd217391, 32'd232558,
    32'd250000, 32'd270270, 32'd303030, 32'd333333, 32'd370370, 32'd400000, 32'd434783,
    32'd476190, 32'd500000
  };

  localparam logic [31:0] DELAY_TAB [4] = '{32'd250000, 32'd500000, 32'd750000, 32'd1000000};

  localparam logic [7:0] PAUSE_SEQ [8] = '{8'he1, 8'h14, 8'h77, 8'he1, 8'hf0, 8'h14, 8'hf0, 8'h77};
  localparam logic [7:0] PRT_MK_SEQ [4] = '{8'he0, 8'h12, 8'he0, 8'h7c};
  localparam logic [7:0] PRT_BR_SEQ [6] = '{8'he0, 8'hf0, 8'h7c, 8'he0, 8'hf0, 8'h12};

  function automatic logic [3:0] key_len(input logic mk, input logic [7:0] key);
    logic [3:0] n;
    if (key == KEY_PAUSE) begin
      n = mk ? 4'd8 : 4'd0;
    end else if (key == KEY_PRTSC) begin
      n = mk ? 4'd4 : 4'd6;
    end else begin
      n = 4'd1 + {3'd0, !PLAIN_MAP[key]} + {3'd0, !mk};
    end
    return n;
  endfunction

  function automatic logic [7:0] key_seq(input logic mk, input logic [7:0] key,
                                         input logic [2:0] k);
    logic [7:0] b;
    logic [2:0] idx;
    idx = k;
    b = CODE_TAB[key];
    if (key == KEY_PAUSE) begin
      b = PAUSE_SEQ[idx];
    end else if (key == KEY_PRTSC) begin
      if (mk) begin
        b = PRT_MK_SEQ[idx[1:0]];
      end else begin
        b = (idx < 3'd6) ? PRT_BR_SEQ[idx] : PRT_BR_SEQ[0];
      end
    end else begin
      if (!PLAIN_MAP[key]) begin
        if (idx == 3'd0) begin
          b = B_EXT;
        end
        idx = idx - 3'd1;
      end
      if (!mk && (PLAIN_MAP[key] || k != 3'd0)) begin
        if (idx == 3'd0) begin
          b = B_BREAK;
        end
      end
    end
    return b;
  endfunction

endpackage

// File: rtl/ps2kbd_ctrl.sv
module ps2kbd_ctrl
  import ps2kbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t st,
  output ctl_cmd_t  c
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_HOST  = 9'b000000100,
    S_REMIT = 9'b000001000,
    S_KEY   = 9'b000010000,
    S_TCHK  = 9'b000100000,
    S_TEMIT = 9'b001000000,
    S_TUPD  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    c = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          c.ld_item = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.is_host) begin
          state_next = S_HOST;
        end else if (!st.active) begin
          state_next = S_FLUSH;
        end else if (st.is_tick) begin
          c.tick_start = 1'b1;
          state_next = S_TCHK;
        end else begin
          state_next = S_KEY;
        end
      end
      S_HOST: begin
        c.do_host = 1'b1;
        c.k_clr = 1'b1;
        state_next = S_REMIT;
      end
      S_REMIT: begin
        if (st.can_push) begin
          c.emit_reply = 1'b1;
          if (st.last_r) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_KEY: begin
        c.do_key = 1'b1;
        state_next = S_FLUSH;
      end
      S_TCHK: begin
        c.k_clr = 1'b1;
        if (!st.eligible) begin
          if (st.wi_last) begin
            state_next = S_FLUSH;
          end else begin
            c.walk_next = 1'b1;
          end
        end else if (!st.fits) begin
          state_next = S_FLUSH;
        end else if (st.zero_len) begin
          state_next = S_TUPD;
        end else begin
          state_next = S_TEMIT;
        end
      end
      S_TEMIT: begin
        if (st.can_push) begin
          c.emit_key = 1'b1;
          if (st.last_k) begin
            state_next = S_TUPD;
          end
        end
      end
      S_TUPD: begin
        c.slot_upd = 1'b1;
        if (st.wi_last) begin
          state_next = S_FLUSH;
        end else begin
          c.walk_next = 1'b1;
          state_next = S_TCHK;
        end
      end
      S_FLUSH: begin
        if (!st.hvalid) begin
          state_next = S_IDLE;
        end else if (st.can_push) begin
          c.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ps2kbd_dp.sv
module ps2kbd_dp
  import ps2kbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  input  ctl_cmd_t  c,
  output ctl_stat_t st,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [1:0]       phase [KEY_SLOTS];
  logic [7:0]       skey  [KEY_SLOTS];
  logic [31:0]      due   [KEY_SLOTS];
  logic [REP_W-1:0] rep;
  logic [1:0]       pend;
  logic [6:0]       tm;
  logic             scan_en;
  logic [2:0]       led;
  logic             leds_present;

  in_item_t         item;
  logic [IDX_W-1:0] wi;
  logic [2:0]       k;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       rb [3];
  logic [1:0]       rn;
  logic [7:0]       hold;
  logic             hvalid;

  logic [1:0]  cph;
  logic [7:0]  ckey;
  logic        mk;
  logic [3:0]  n;
  logic [7:0]  ebyte;
  logic        emit;
  logic        push;
  logic        dup;
  logic        free_found;
  logic [IDX_W-1:0] free_idx;
  logic        rel_found;
  logic [IDX_W-1:0] rel_idx;
  logic [CNT_W:0] cnt_sum;
  logic [7:0]  rb0_n;
  logic [7:0]  rb1_n;
  logic [1:0]  rn_n;

  assign cph = phase[wi];
  assign ckey = skey[wi];
  assign mk = (cph != PH_RELEASED);
  assign n = key_len(mk, ckey);
  assign cnt_sum = {1'b0, cnt} + (CNT_W + 1)'(n);
  assign emit = c.emit_reply || c.emit_key;
  assign ebyte = c.emit_reply ? rb[k[1:0]] : key_seq(mk, ckey, k);
  assign push = (emit && hvalid) || c.flush;

  always_comb begin
    st.is_host  = (item.cmd == CMD_HOST);
    st.is_tick  = (item.cmd == CMD_TICK);
    st.active   = scan_en && (pend == SUB_NONE);
    st.eligible = (cph != PH_FREE) && (due[wi] <= item.now_us) &&
                  !((cph == PH_HOLD) && (rep != REP_W'(wi)));
    st.fits     = (cnt_sum <= (CNT_W + 1)'(MAX_RESULTS));
    st.zero_len = (n == 4'd0);
    st.last_k   = ({1'b0, k} == n - 4'd1);
    st.last_r   = ({1'b0, k} == {2'b0, rn} - 4'd1);
    st.wi_last  = (wi == IDX_W'(KEY_SLOTS - 1));
    st.can_push = !out_valid || out_ready;
    st.hvalid   = hvalid;
  end

  always_comb begin
    dup = 1'b0;
    free_found = 1'b0;
    free_idx = '0;
    rel_found = 1'b0;
    rel_idx = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if ((phase[i] == PH_PRESSED || phase[i] == PH_HOLD) && skey[i] == item.data) begin
        dup = 1'b1;
        if (!rel_found) begin
          rel_found = 1'b1;
          rel_idx = IDX_W'(i);
        end
      end
      if (phase[i] == PH_FREE && !free_found) begin
        free_found = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rb0_n = B_ACK;
    rb1_n = B_ID0;
    rn_n = 2'd1;
    case (pend)
      SUB_LEDS: begin
      end
      SUB_SET: begin
        if (item.data == 8'd0) begin
          rb1_n = B_SET2;
          rn_n = 2'd2;
        end else if (item.data > 8'd3) begin
          rb0_n = B_RESEND;
        end
      end
      SUB_TYPM: begin
      end
      default: begin
        case (item.data)
          HC_LEDS, HC_SCANSET, HC_TYPM, HC_ENABLE, HC_DISABLE, HC_DEFAULTS: begin
          end
          HC_ECHO: rb0_n = HC_ECHO;
          HC_ID: rn_n = 2'd3;
          HC_RESET: begin
            rb1_n = B_BAT_OK;
            rn_n = 2'd2;
          end
          default: rb0_n = B_RESEND;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (c.ld_item) begin
      item <= in_item;
    end
    if (c.tick_start) begin
      cnt <= '0;
    end else if (c.emit_key) begin
      cnt <= cnt + 1'b1;
    end
    if (c.k_clr) begin
      k <= '0;
    end else if (emit) begin
      k <= k + 3'd1;
    end
    if (emit) begin
      hold <= ebyte;
    end
    if (c.do_key && item.cmd == CMD_PRESS && MAPPED_MAP[item.data] && !dup && free_found) begin
      skey[free_idx] <= item.data;
      due[free_idx] <= item.now_us;
    end
    if (c.do_key && item.cmd == CMD_RELEASE && rel_found) begin
      due[rel_idx] <= item.now_us;
    end
    if (c.slot_upd && cph == PH_HOLD) begin
      due[wi] <= item.now_us + RATE_TAB[tm[4:0]];
    end else if (c.slot_upd && cph == PH_PRESSED) begin
      due[wi] <= item.now_us + DELAY_TAB[tm[6:5]];
    end
    if (push) begin
      out_item.out_byte <= hold;
      out_item.last <= c.flush;
      out_item.led_state <= leds_present ? led : 3'd0;
    end
    if (c.do_host) begin
      rb[0] <= rb0_n;
      rb[1] <= rb1_n;
      rb[2] <= B_ID1;
      rn <= rn_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        phase[i] <= PH_FREE;
      end
      rep <= REP_W'(KEY_SLOTS);
      pend <= SUB_NONE;
      tm <= TYPM_DEF;
      scan_en <= 1'b1;
      led <= 3'd0;
      leds_present <= 1'b1;
      wi <= '0;
      hvalid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        leds_present <= cfg_data;
      end
      if (c.tick_start) begin
        wi <= '0;
      end else if (c.walk_next) begin
        wi <= wi + 1'b1;
      end
      if (emit) begin
        hvalid <= 1'b1;
      end else if (c.flush) begin
        hvalid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (c.do_key && item.cmd == CMD_PRESS && MAPPED_MAP[item.data] && !dup && free_found) begin
        phase[free_idx] <= PH_PRESSED;
      end
      if (c.do_key && item.cmd == CMD_RELEASE && rel_found) begin
        phase[rel_idx] <= PH_RELEASED;
      end
      if (c.slot_upd) begin
        case (cph)
          PH_PRESSED: begin
            if (ckey == KEY_PAUSE) begin
              phase[wi] <= PH_RELEASED;
            end else begin
              phase[wi] <= PH_HOLD;
              rep <= REP_W'(wi);
            end
          end
          PH_RELEASED: begin
            phase[wi] <= PH_FREE;
            if (rep == REP_W'(wi)) begin
              rep <= REP_W'(KEY_SLOTS);
            end
          end
          default: begin
          end
        endcase
      end
      if (c.do_host) begin
        case (pend)
          SUB_LEDS: begin
            pend <= SUB_NONE;
            if (leds_present) begin
              led <= item.data[2:0];
            end
          end
          SUB_SET: begin
            pend <= SUB_NONE;
          end
          SUB_TYPM: begin
            pend <= SUB_NONE;
            tm <= item.data[6:0];
          end
          default: begin
            case (item.data)
              HC_LEDS: pend <= SUB_LEDS;
              HC_SCANSET: pend <= SUB_SET;
              HC_TYPM: pend <= SUB_TYPM;
              HC_ENABLE: scan_en <= 1'b1;
              HC_DISABLE: scan_en <= 1'b0;
              HC_DEFAULTS, HC_RESET: begin
                tm <= TYPM_DEF;
                led <= 3'd0;
                scan_en <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/ps2kbd_top.sv
// PS/2 keyboard device, scan set 2. Items are host bytes, key presses and releases, and
// time ticks; every byte sent to the host comes out as one result, the final one of an
// item flagged with last. A host byte is answered with its reply bytes; a key event
// updates the slot table. A tick walks the slot table one slot at a time, skipping slots
// with nothing due and sending the scancode bytes of each serviced slot.
// Key and tick items while scanning is off or a sub-command is pending are dropped.
// A waiting byte is held back for as long as out_ready holds it off.
module ps2_keyboard_scancode_engine_top
  import ps2kbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  ctl_cmd_t  c;
  ctl_stat_t st;

  assign cfg_ready = 1'b1;

  ps2kbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .c        (c)
  );

  ps2kbd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .c         (c),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !st.hvalid)
    else $error("request taken with a byte still held");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (c.emit_key || c.emit_reply || c.flush) |-> st.can_push)
    else $error("byte pushed into a full output stage");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    c.flush |=> (out_valid && out_item.last))
    else $error("final byte not flagged last");

endmodule
